### hdl/cbb_pkg.sv
// Shared types and codes for the circular byte buffer with pattern find.
package cbb_pkg;

    localparam int PAT_W     = 64;
    localparam int LEN_W     = 4;
    localparam int PAT_BYTES = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] REQ_APPEND  = 2'd0;
    localparam logic [1:0] REQ_POP     = 2'd1;
    localparam logic [1:0] REQ_DISCARD = 2'd2;
    localparam logic [1:0] REQ_FIND    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 1'd1;

    typedef struct packed {
        logic append;
        logic pop_start;
        logic pop_finish;
        logic discard;
        logic find_start;
        logic find_scan;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic find_quick;
        logic scan_hit;
        logic scan_miss;
    } stat_t;

endpackage

### hdl/circular_byte_buffer_with_pattern_find.sv
// Top level of the circular byte buffer with pattern find.
//
// A request is taken when start is high and busy is low; its single result
// appears on the result ports for one cycle with done high, and must be taken
// then. Append and discard show done in the cycle after the request and accept
// a new request every cycle. A pop of a non-empty buffer waits in the S_POP
// state for the registered read port of the byte store. Find shows done in the
// cycle after the request when the pattern length is zero or exceeds the fill
// level; otherwise it reads the store one byte per cycle from the head through
// the single read port, and shows done once the pattern matches or every stored
// byte has been seen. The store needs no clearing after reset.
module circular_byte_buffer_with_pattern_find #(
    parameter int   DEPTH       = 1024,
    parameter int   PATTERN_MAX = 8,
    localparam int  CNT_W       = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    req_type,
    input  logic [7:0]                    data_in,
    input  logic [CNT_W-1:0]              skip_count,
    input  logic                          cfg_we,
    input  logic [cbb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbb_pkg::PAT_W-1:0]     cfg_data,
    output logic                          done,
    output logic [7:0]                    data_out,
    output logic [CNT_W-1:0]              match_offset,
    output logic [1:0]                    status,
    output logic [CNT_W-1:0]              fill_level
);
    import cbb_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    cbb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    cbb_datapath #(
        .DEPTH       (DEPTH),
        .PATTERN_MAX (PATTERN_MAX),
        .CNT_W       (CNT_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .data_in      (data_in),
        .skip_count   (skip_count),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_out     (data_out),
        .match_offset (match_offset),
        .status       (status),
        .fill_level   (fill_level)
    );

endmodule

### hdl/cbb_ctrl.sv
// Request sequencer for the circular byte buffer.
module cbb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    req_type,
    input  cbb_pkg::stat_t stat,
    output cbb_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done
);
    import cbb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_FIND = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_APPEND:
                        begin
                            cmd.append = 1'b1;
                            done_next  = 1'b1;
                        end
                        REQ_POP:
                        begin
                            cmd.pop_start = 1'b1;
                            if (stat.empty)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                        REQ_DISCARD:
                        begin
                            cmd.discard = 1'b1;
                            done_next   = 1'b1;
                        end
                        default:
                        begin
                            cmd.find_start = 1'b1;
                            if (stat.find_quick)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                    endcase
                end
            end
            S_POP:
            begin
                cmd.pop_finish = 1'b1;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
            S_FIND:
            begin
                cmd.find_scan = 1'b1;
                if (stat.scan_hit || stat.scan_miss)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

### hdl/cbb_datapath.sv
// Byte store, pointers, pattern registers, match window and result registers.
module cbb_datapath #(
    parameter int DEPTH       = 1024,
    parameter int PATTERN_MAX = 8,
    parameter int CNT_W       = 11
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cbb_pkg::cmd_t                cmd,
    output cbb_pkg::stat_t               stat,
    input  logic [7:0]                   data_in,
    input  logic [CNT_W-1:0]             skip_count,
    input  logic                         cfg_we,
    input  logic [cbb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbb_pkg::PAT_W-1:0]    cfg_data,
    output logic [7:0]                   data_out,
    output logic [CNT_W-1:0]             match_offset,
    output logic [1:0]                   status,
    output logic [CNT_W-1:0]             fill_level
);
    import cbb_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [7:0]       mem [DEPTH];
    logic [7:0]       ram_q_reg;
    logic             mem_we;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;

    logic [AW-1:0]    head_reg;
    logic [AW-1:0]    head_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    logic [PAT_W-1:0] pattern_reg;
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] len_eff;
    logic [7:0]       pat_byte [PAT_BYTES];

    logic [AW-1:0]    scan_addr_reg;
    logic [AW-1:0]    scan_addr_next;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic [CNT_W-1:0] rd_cnt_next;
    logic [CNT_W-1:0] in_cnt_reg;
    logic [CNT_W-1:0] in_cnt_next;
    logic             rd_vld_reg;
    logic             rd_vld_next;
    logic [7:0]       win_reg  [PATTERN_MAX];
    logic [7:0]       win_next [PATTERN_MAX];
    logic             win_match;
    logic [CNT_W-1:0] cnt_seen;
    logic [CMP_W-1:0] len_cmp;
    logic [CMP_W-1:0] fill_cmp;
    logic [CMP_W-1:0] seen_cmp;
    logic [CMP_W-1:0] offset_cmp;

    logic             res_load;
    logic [7:0]       res_data;
    logic [CNT_W-1:0] res_offset;
    logic [1:0]       res_status;
    logic [7:0]       data_out_reg;
    logic [CNT_W-1:0] match_offset_reg;
    logic [1:0]       status_reg;
    logic [CNT_W-1:0] fill_level_reg;

    always_comb
    begin
        for (int k = 0; k < PAT_BYTES; k++)
        begin
            pat_byte[k] = pattern_reg[8*k +: 8];
        end
        if (length_reg > LEN_W'(PATTERN_MAX))
        begin
            len_eff = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len_eff = length_reg;
        end
    end

    assign len_cmp    = CMP_W'(len_eff);
    assign fill_cmp   = CMP_W'(fill_reg);
    assign cnt_seen   = in_cnt_reg + CNT_W'(1);
    assign seen_cmp   = CMP_W'(cnt_seen);
    assign offset_cmp = seen_cmp - len_cmp;

    always_comb
    begin
        logic [LEN_W-1:0] pidx;
        win_next[0] = ram_q_reg;
        for (int i = 1; i < PATTERN_MAX; i++)
        begin
            win_next[i] = win_reg[i-1];
        end
        win_match = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pidx = len_eff - LEN_W'(1) - LEN_W'(i);
            if ((LEN_W'(i) < len_eff) && (win_next[i] != pat_byte[pidx[2:0]]))
            begin
                win_match = 1'b0;
            end
        end
    end

    assign stat.empty      = (fill_reg == '0);
    assign stat.find_quick = (len_eff == '0) || (len_cmp > fill_cmp);
    assign stat.scan_hit   = rd_vld_reg && (seen_cmp >= len_cmp) && win_match;
    assign stat.scan_miss  = rd_vld_reg && (cnt_seen == fill_reg) && !stat.scan_hit;

    always_comb
    begin
        head_next      = head_reg;
        fill_next      = fill_reg;
        mem_we         = 1'b0;
        wr_addr        = wrap_add(head_reg, fill_reg);
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        scan_addr_next = scan_addr_reg;
        rd_cnt_next    = rd_cnt_reg;
        in_cnt_next    = in_cnt_reg;
        rd_vld_next    = 1'b0;
        res_load       = 1'b0;
        res_data       = '0;
        res_offset     = '0;
        res_status     = ST_OK;

        if (cmd.append)
        begin
            res_load = 1'b1;
            if (fill_reg == CNT_W'(DEPTH))
            begin
                res_status = ST_FULL;
            end
            else
            begin
                mem_we    = 1'b1;
                fill_next = fill_reg + CNT_W'(1);
            end
        end
        else if (cmd.pop_start)
        begin
            if (stat.empty)
            begin
                res_load   = 1'b1;
                res_status = ST_EMPTY;
            end
            else
            begin
                rd_en = 1'b1;
            end
        end
        else if (cmd.pop_finish)
        begin
            res_load  = 1'b1;
            res_data  = ram_q_reg;
            head_next = wrap_add(head_reg, CNT_W'(1));
            fill_next = fill_reg - CNT_W'(1);
        end
        else if (cmd.discard)
        begin
            res_load = 1'b1;
            if (skip_count > fill_reg)
            begin
                head_next  = wrap_add(head_reg, fill_reg);
                fill_next  = '0;
                res_status = ST_EMPTY;
            end
            else
            begin
                head_next = wrap_add(head_reg, skip_count);
                fill_next = fill_reg - skip_count;
            end
        end
        else if (cmd.find_start)
        begin
            scan_addr_next = head_reg;
            rd_cnt_next    = '0;
            in_cnt_next    = '0;
            if (len_eff == '0)
            begin
                res_load = 1'b1;
            end
            else if (len_cmp > fill_cmp)
            begin
                res_load   = 1'b1;
                res_status = ST_NOTFOUND;
            end
        end
        else if (cmd.find_scan)
        begin
            if (rd_cnt_reg < fill_reg)
            begin
                rd_en          = 1'b1;
                rd_addr        = scan_addr_reg;
                scan_addr_next = wrap_add(scan_addr_reg, CNT_W'(1));
                rd_cnt_next    = rd_cnt_reg + CNT_W'(1);
                rd_vld_next    = 1'b1;
            end
            if (rd_vld_reg)
            begin
                in_cnt_next = cnt_seen;
            end
            if (stat.scan_hit)
            begin
                res_load   = 1'b1;
                res_offset = offset_cmp[CNT_W-1:0];
            end
            else if (stat.scan_miss)
            begin
                res_load   = 1'b1;
                res_status = ST_NOTFOUND;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= data_in;
        end
        if (rd_en)
        begin
            ram_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.find_scan && rd_vld_reg)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            fill_reg         <= '0;
            pattern_reg      <= '0;
            length_reg       <= LEN_W'(1);
            scan_addr_reg    <= '0;
            rd_cnt_reg       <= '0;
            in_cnt_reg       <= '0;
            rd_vld_reg       <= 1'b0;
            data_out_reg     <= '0;
            match_offset_reg <= '0;
            status_reg       <= ST_OK;
            fill_level_reg   <= '0;
        end
        else
        begin
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            scan_addr_reg <= scan_addr_next;
            rd_cnt_reg    <= rd_cnt_next;
            in_cnt_reg    <= in_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PATTERN: pattern_reg <= cfg_data;
                    CFG_LENGTH:  length_reg  <= cfg_data[LEN_W-1:0];
                    default:     pattern_reg <= pattern_reg;
                endcase
            end
            if (res_load)
            begin
                data_out_reg     <= res_data;
                match_offset_reg <= res_offset;
                status_reg       <= res_status;
                fill_level_reg   <= fill_next;
            end
        end
    end

    assign data_out     = data_out_reg;
    assign match_offset = match_offset_reg;
    assign status       = status_reg;
    assign fill_level   = fill_level_reg;

endmodule
